// ===== hw/rtl/json_string_unescape_utf8_unit_macros.svh =====
// assertion macros for the json string unescape unit
// used by the top level only, expects clk and rst_n in scope
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// shared types, codes and decode helpers of the json string unescape unit
// no dependencies
`default_nettype none

package jsu_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] BACKSLASH = 8'h5c;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TEXT,
    PH_ESC,
    PH_HEX
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA,
    ST_DONE,
    ST_BADESC,
    ST_BADHEX,
    ST_NOQUOTE
  } status_t;

  // what one queue entry asks the back end to produce
  typedef enum logic [1:0] {
    CK_BYTE,
    CK_CP,
    CK_STATUS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] val;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic       is_u;
    logic [7:0] val;
  } esc_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h57);
    end
    return r;
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] b);
    esc_t r;
    r = '0;
    unique case (b)
      8'h22: begin r.ok = 1'b1; r.val = 8'h22; end
      8'h5c: begin r.ok = 1'b1; r.val = 8'h5c; end
      8'h2f: begin r.ok = 1'b1; r.val = 8'h2f; end
      8'h62: begin r.ok = 1'b1; r.val = 8'h08; end
      8'h66: begin r.ok = 1'b1; r.val = 8'h0c; end
      8'h6e: begin r.ok = 1'b1; r.val = 8'h0a; end
      8'h72: begin r.ok = 1'b1; r.val = 8'h0d; end
      8'h74: begin r.ok = 1'b1; r.val = 8'h09; end
      8'h75: begin r.is_u = 1'b1; end
      default: begin r.ok = 1'b0; end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8_unit.sv =====
// path: each byte's command passes the command queue, then the output register
// throughput: one input byte per cycle; one result per cycle while out_tready is high and the
//   queue holds a command; a \u escape gives up to three results, bursts are absorbed by the command queue
// input stalls only while the command queue (QUEUE_DEPTH entries) is full
// reset: synchronous active-low rst_n clears string state, queue and output
//   valid; the block then waits for an opening delimiter
`default_nettype none

`include "json_string_unescape_utf8_unit_macros.svh"

module json_string_unescape_utf8_unit #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [2:0]      out_tuser,  // [2:0] status
  output logic            out_tlast   // last result of this input byte
);

  jsu_pkg::cmd_t    f_cmd;
  jsu_pkg::cmd_t    q_head;
  jsu_pkg::q_stat_t q_stat;
  logic             f_push;
  logic             b_pop;
  logic             in_fire;

  // front end only waits on queue room, never on the result side directly
  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;

  // string/escape/hex tracking, one command per result-producing byte
  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .cmd     (f_cmd),
    .push    (f_push)
  );

  // decouples the one-byte-per-cycle front from multi-byte utf-8 output
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wr_cmd (f_cmd),
    .pop    (b_pop),
    .head   (q_head),
    .stat   (q_stat)
  );

  // utf-8 expansion and registered result transfer
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .stat       (q_stat),
    .pop        (b_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  // queue is never written while full
  `JSU_ASSERT_IMP(a_no_overflow, f_push, !q_stat.full, "command queue overflow")
  // back end never consumes from an empty queue
  `JSU_ASSERT_IMP(a_no_underflow, b_pop, !q_stat.empty, "command queue underflow")
  // status results carry a zero byte and close their input byte
  `JSU_ASSERT_IMP(a_status_form, out_tvalid && (out_tuser != jsu_pkg::ST_DATA),
                  (out_tdata == 8'h00) && out_tlast, "malformed status result")

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
// front end: takes text bytes, tracks string and escape state, issues commands
// depends on jsu_pkg
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic [7:0]    in_byte,
  output jsu_pkg::cmd_t      cmd,
  output logic               push
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      delim_r, delim_nxt;
  logic [1:0]      hcnt_r, hcnt_nxt;
  logic [15:0]     cp_r, cp_nxt;
  jsu_pkg::hex_t   hx;
  jsu_pkg::esc_t   ex;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_IDLE;
      delim_r <= '0;
      hcnt_r  <= '0;
      cp_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      delim_r <= delim_nxt;
      hcnt_r  <= hcnt_nxt;
      cp_r    <= cp_nxt;
    end
  end

  always_comb begin
    hx        = jsu_pkg::hex_decode(in_byte);
    ex        = jsu_pkg::esc_decode(in_byte);
    phase_nxt = phase_r;
    delim_nxt = delim_r;
    hcnt_nxt  = hcnt_r;
    cp_nxt    = cp_r;
    push      = 1'b0;
    cmd       = '0;
    if (in_fire) begin
      unique case (phase_r)
        jsu_pkg::PH_IDLE: begin
          delim_nxt = in_byte;
          phase_nxt = jsu_pkg::PH_TEXT;
        end
        jsu_pkg::PH_TEXT: begin
          // delimiter wins over end of text and backslash
          priority if (in_byte == delim_r) begin
            push      = 1'b1;
            cmd.kind  = jsu_pkg::CK_STATUS;
            cmd.val   = 16'(jsu_pkg::ST_DONE);
            phase_nxt = jsu_pkg::PH_IDLE;
          end else if (in_byte == 8'h00) begin
            push      = 1'b1;
            cmd.kind  = jsu_pkg::CK_STATUS;
            cmd.val   = 16'(jsu_pkg::ST_NOQUOTE);
            phase_nxt = jsu_pkg::PH_IDLE;
          end else if (in_byte == jsu_pkg::BACKSLASH) begin
            phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            push     = 1'b1;
            cmd.kind = jsu_pkg::CK_BYTE;
            cmd.val  = {8'h00, in_byte};
          end
        end
        jsu_pkg::PH_ESC: begin
          priority if (ex.is_u) begin
            phase_nxt = jsu_pkg::PH_HEX;
            hcnt_nxt  = '0;
            cp_nxt    = '0;
          end else if (ex.ok) begin
            push      = 1'b1;
            cmd.kind  = jsu_pkg::CK_BYTE;
            cmd.val   = {8'h00, ex.val};
            phase_nxt = jsu_pkg::PH_TEXT;
          end else begin
            push      = 1'b1;
            cmd.kind  = jsu_pkg::CK_STATUS;
            cmd.val   = 16'(jsu_pkg::ST_BADESC);
            phase_nxt = jsu_pkg::PH_IDLE;
          end
        end
        jsu_pkg::PH_HEX: begin
          if (!hx.ok) begin
            push      = 1'b1;
            cmd.kind  = jsu_pkg::CK_STATUS;
            cmd.val   = 16'(jsu_pkg::ST_BADHEX);
            phase_nxt = jsu_pkg::PH_IDLE;
          end else begin
            cp_nxt = {cp_r[11:0], hx.val};
            if (hcnt_r == 2'd3) begin
              push      = 1'b1;
              cmd.kind  = jsu_pkg::CK_CP;
              cmd.val   = {cp_r[11:0], hx.val};
              hcnt_nxt  = '0;
              phase_nxt = jsu_pkg::PH_TEXT;
            end else begin
              hcnt_nxt = hcnt_r + 2'd1;
            end
          end
        end
        default: phase_nxt = jsu_pkg::PH_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
// command queue between front and back end, register array with pointers
// depends on jsu_pkg
`default_nettype none

module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jsu_pkg::cmd_t wr_cmd,
  input  wire logic          pop,
  output jsu_pkg::cmd_t      head,
  output jsu_pkg::q_stat_t   stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
// back end: expands queued commands into result transfers, one per cycle
// while out_ready is high and a command is queued; depends on jsu_pkg
`default_nettype none

module jsu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jsu_pkg::cmd_t    head,
  input  wire jsu_pkg::q_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic [2:0]            out_status,
  output logic                  out_last
);

  logic [1:0] step_r, step_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_c;
  logic [2:0] stat_r, stat_c;
  logic       last_r, last_c;
  logic       load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      byte_r <= byte_c;
      stat_r <= stat_c;
      last_r <= last_c;
    end
  end

  // piece of the head command selected by step_r
  always_comb begin
    byte_c = '0;
    stat_c = jsu_pkg::ST_DATA;
    last_c = 1'b1;
    unique case (head.kind)
      jsu_pkg::CK_BYTE: byte_c = head.val[7:0];
      jsu_pkg::CK_STATUS: stat_c = head.val[2:0];
      jsu_pkg::CK_CP: begin
        if (head.val < 16'h0080) begin
          byte_c = head.val[7:0];
        end else if (head.val < 16'h0800) begin
          if (step_r == 2'd0) begin
            byte_c = {3'b110, head.val[10:6]};
            last_c = 1'b0;
          end else begin
            byte_c = {2'b10, head.val[5:0]};
          end
        end else begin
          unique case (step_r)
            2'd0: begin
              byte_c = {4'b1110, head.val[15:12]};
              last_c = 1'b0;
            end
            2'd1: begin
              byte_c = {2'b10, head.val[11:6]};
              last_c = 1'b0;
            end
            default: byte_c = {2'b10, head.val[5:0]};
          endcase
        end
      end
      default: stat_c = jsu_pkg::ST_DATA;
    endcase
  end

  always_comb begin
    load     = !vld_r || out_ready;
    vld_nxt  = vld_r;
    step_nxt = step_r;
    pop      = 1'b0;
    if (load) begin
      vld_nxt = !stat.empty;
      if (!stat.empty) begin
        if (last_c) begin
          pop      = 1'b1;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
    end
  end

  assign out_valid  = vld_r;
  assign out_byte   = byte_r;
  assign out_status = stat_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ===== tb/tb_json_string_unescape_utf8_unit.sv =====
// self-checking testbench for the json string unescape unit: quoted strings
// go in one byte per transfer, decoded utf-8 bytes and statuses are checked
// against a behavioral predictor; depends on jsu_pkg and the unit's rtl
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_unit;

  localparam int MAX_CYCLES   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // text characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_G = 8'h47;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_N = 8'h6e;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_U = 8'h75;

  // control bytes the short escapes stand for
  localparam logic [7:0] CTL_BACKSPACE = 8'h08;
  localparam logic [7:0] CTL_TAB       = 8'h09;
  localparam logic [7:0] CTL_NEWLINE   = 8'h0a;
  localparam logic [7:0] CTL_FORMFEED  = 8'h0c;
  localparam logic [7:0] CTL_RETURN    = 8'h0d;

  // utf-8 prefixes
  localparam logic [7:0] UTF8_LEAD2 = 8'd192;
  localparam logic [7:0] UTF8_LEAD3 = 8'd224;
  localparam logic [7:0] UTF8_CONT  = 8'd128;

  localparam logic [7:0] SHORT_ESCAPES [8] = '{CH_QUOTE, jsu_pkg::BACKSLASH, CH_SLASH,
                                               CH_LOWER_B, CH_LOWER_F, CH_LOWER_N,
                                               CH_LOWER_R, CH_LOWER_T};

  typedef struct packed {
    logic [7:0]       out_byte;
    jsu_pkg::status_t status;
    logic             last;
  } utf8_result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  // decoder state as the predictor sees it
  jsu_pkg::phase_t parse_phase   = jsu_pkg::PH_IDLE;
  logic [7:0]      closing_quote = 8'h00;
  logic [1:0]      digits_seen   = 2'd0;
  logic [15:0]     code_point    = 16'h0000;

  utf8_result_t expected_results[$];

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_left         = 0;
  int bytes_sent        = 0;
  int mismatches        = 0;
  int cycle_count       = 0;

  json_string_unescape_utf8_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte
    .out_tuser  (out_tuser),   // [2:0] status
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: long hold-off when asked, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_hex_char(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UPPER_A && b <= CH_UPPER_F) ||
           (b >= CH_LOWER_A && b <= CH_LOWER_F);
  endfunction

  function automatic logic [3:0] hex_char_value(input logic [7:0] b);
    if (b <= CH_NINE) return 4'(b - CH_ZERO);
    if (b <= CH_UPPER_F) return 4'(b - CH_UPPER_A + 8'd10);
    return 4'(b - CH_LOWER_A + 8'd10);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nibble, input logic upper);
    if (nibble < 4'd10) return CH_ZERO + 8'(nibble);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nibble - 4'd10);
  endfunction

  function automatic void queue_result(input logic [7:0] b, input jsu_pkg::status_t st,
                                       input logic last);
    utf8_result_t r;
    r.out_byte = b;
    r.status   = st;
    r.last     = last;
    expected_results = {expected_results, r};
  endfunction

  // error or done: single result, back to waiting for an opening delimiter
  function automatic void close_string(input jsu_pkg::status_t st);
    queue_result(8'h00, st, 1'b1);
    parse_phase = jsu_pkg::PH_IDLE;
  endfunction

  function automatic void queue_utf8(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      queue_result(cp[7:0], jsu_pkg::ST_DATA, 1'b1);
    end else if (cp < 16'h0800) begin
      queue_result(UTF8_LEAD2 | {3'b000, cp[10:6]}, jsu_pkg::ST_DATA, 1'b0);
      queue_result(UTF8_CONT | {2'b00, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
    end else begin
      queue_result(UTF8_LEAD3 | {4'h0, cp[15:12]}, jsu_pkg::ST_DATA, 1'b0);
      queue_result(UTF8_CONT | {2'b00, cp[11:6]}, jsu_pkg::ST_DATA, 1'b0);
      queue_result(UTF8_CONT | {2'b00, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    case (parse_phase)
      jsu_pkg::PH_IDLE: begin
        closing_quote = b;
        parse_phase   = jsu_pkg::PH_TEXT;
      end
      jsu_pkg::PH_TEXT: begin
        // the delimiter wins even when it is a backslash or zero
        if (b == closing_quote) close_string(jsu_pkg::ST_DONE);
        else if (b == CH_NUL) close_string(jsu_pkg::ST_NOQUOTE);
        else if (b == jsu_pkg::BACKSLASH) parse_phase = jsu_pkg::PH_ESC;
        else queue_result(b, jsu_pkg::ST_DATA, 1'b1);
      end
      jsu_pkg::PH_ESC: begin
        parse_phase = jsu_pkg::PH_TEXT;
        case (b)
          CH_QUOTE:   queue_result(CH_QUOTE, jsu_pkg::ST_DATA, 1'b1);
          jsu_pkg::BACKSLASH: queue_result(jsu_pkg::BACKSLASH, jsu_pkg::ST_DATA, 1'b1);
          CH_SLASH:   queue_result(CH_SLASH, jsu_pkg::ST_DATA, 1'b1);
          CH_LOWER_B: queue_result(CTL_BACKSPACE, jsu_pkg::ST_DATA, 1'b1);
          CH_LOWER_F: queue_result(CTL_FORMFEED, jsu_pkg::ST_DATA, 1'b1);
          CH_LOWER_N: queue_result(CTL_NEWLINE, jsu_pkg::ST_DATA, 1'b1);
          CH_LOWER_R: queue_result(CTL_RETURN, jsu_pkg::ST_DATA, 1'b1);
          CH_LOWER_T: queue_result(CTL_TAB, jsu_pkg::ST_DATA, 1'b1);
          CH_LOWER_U: begin
            parse_phase = jsu_pkg::PH_HEX;
            digits_seen = 2'd0;
            code_point  = 16'h0000;
          end
          default: close_string(jsu_pkg::ST_BADESC);
        endcase
      end
      default: begin
        if (!is_hex_char(b)) begin
          close_string(jsu_pkg::ST_BADHEX);
        end else begin
          code_point = {code_point[11:0], hex_char_value(b)};
          if (digits_seen != 2'd3) begin
            digits_seen = digits_seen + 2'd1;
          end else begin
            digits_seen = 2'd0;
            parse_phase = jsu_pkg::PH_TEXT;
            queue_utf8(code_point);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  always @(negedge clk) begin : check_results
    utf8_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte %02h status %0d last %0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.out_byte || out_tuser !== want.status ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected byte %02h status %0d last %0b, got %02h %0d %0b",
                     want.out_byte, want.status, want.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one byte transfer; ready is sampled at the falling edge before the accepting edge
  task automatic send_byte(input logic [7:0] b);
    logic accepted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      accepted = in_tready;
      @(posedge clk);
    end while (!accepted);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_escape(input logic [7:0] letter);
    send_byte(jsu_pkg::BACKSLASH);
    send_byte(letter);
  endtask

  task automatic send_unicode(input logic [15:0] cp, input logic [3:0] upper);
    send_escape(CH_LOWER_U);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[4*i +: 4], upper[i]));
  endtask

  // a zero byte ends whatever string is open, so directed parts start from idle
  task automatic end_open_string();
    while (parse_phase != jsu_pkg::PH_IDLE) send_byte(CH_NUL);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_short_escapes();
    end_open_string();
    send_byte(CH_QUOTE);
    foreach (SHORT_ESCAPES[i]) send_escape(SHORT_ESCAPES[i]);
    send_byte(CH_NUL);                       // no closing quote
    wait_drained();
  endtask

  task automatic test_unicode_zero_delimiter();
    end_open_string();
    send_byte(CH_NUL);                       // zero taken as the delimiter
    send_byte(8'hff);
    send_unicode(16'h0000, 4'b0000);         // one data byte of value zero
    send_unicode(16'h07ff, 4'b0001);         // two-byte form, mixed case
    send_unicode(16'hffff, 4'b1010);         // three-byte form
    send_byte(CH_NUL);                       // closes the string, not an error
    wait_drained();
  endtask

  task automatic test_backslash_delimiter();
    end_open_string();
    send_byte(jsu_pkg::BACKSLASH);
    send_byte(8'h01);
    send_byte(jsu_pkg::BACKSLASH);           // closes instead of escaping
    wait_drained();
  endtask

  task automatic test_broken_escapes();
    end_open_string();
    send_byte(CH_QUOTE);
    send_escape(CH_NUL);                     // end of text after backslash
    send_byte(CH_QUOTE);
    send_escape(CH_LOWER_Q);                 // unknown escape letter
    send_byte(CH_QUOTE);
    send_unicode(16'h0000, 4'b0000);
    send_escape(CH_LOWER_U);
    send_byte(CH_UPPER_A);
    send_byte(CH_NUL);                       // end of text among hex digits
    send_byte(CH_QUOTE);
    send_escape(CH_LOWER_U);
    send_byte(CH_NINE);
    send_byte(CH_UPPER_G);                   // not a hex digit
    wait_drained();
  endtask

  task automatic send_random_string();
    logic [7:0]  delim;
    logic [7:0]  b;
    logic [15:0] cp;
    int          n_parts;
    case ($urandom_range(9))
      0: delim = CH_NUL;
      1: delim = jsu_pkg::BACKSLASH;
      2, 3: delim = 8'($urandom_range(255));
      default: delim = CH_QUOTE;
    endcase
    // noise: raw bytes in whatever state the decoder is in
    if ($urandom_range(11) == 0) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
      return;
    end
    send_byte(delim);
    n_parts = $urandom_range(0, 6);
    repeat (n_parts) begin
      if (delim == jsu_pkg::BACKSLASH || $urandom_range(3) < 2) begin
        do b = 8'($urandom_range(1, 255)); while (b == delim || b == jsu_pkg::BACKSLASH);
        send_byte(b);
      end else if ($urandom_range(1) == 0) begin
        send_escape(SHORT_ESCAPES[$urandom_range(7)]);
      end else begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h007f));
          1: cp = 16'($urandom_range(16'h07ff, 16'h0080));
          default: cp = 16'($urandom_range(16'hffff, 16'h0800));
        endcase
        send_unicode(cp, 4'($urandom_range(15)));
      end
    end
    case ($urandom_range(9))
      0: send_byte(CH_NUL);
      1: begin
        do b = 8'($urandom_range(255));
        while (b == CH_LOWER_U || b inside {SHORT_ESCAPES});
        send_escape(b);
      end
      2: begin
        send_escape(CH_LOWER_U);
        repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15)), 1'($urandom)));
        do b = 8'($urandom_range(255)); while (is_hex_char(b));
        send_byte(b);
      end
      default: send_byte(delim);
    endcase
  endtask

  task automatic test_random_strings(input int s_pct, input int r_pct, input int count);
    int start;
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_string();
    wait_drained();
  endtask

  // receiver holds off while \u escapes arrive back to back, so the queue fills
  task automatic test_output_stall();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    end_open_string();
    hold_left = 96;
    send_byte(CH_QUOTE);
    repeat (4) send_unicode(16'($urandom_range(16'hffff, 16'h0800)), 4'($urandom_range(15)));
    repeat (8) send_byte(8'($urandom_range(1, 127)) | 8'h01);
    send_byte(CH_QUOTE);
    wait_drained();                          // sender pauses until everything is back
    send_byte(CH_QUOTE);
    send_unicode(16'h0123, 4'b0000);
    send_byte(CH_QUOTE);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_escapes();
    test_unicode_zero_delimiter();
    test_backslash_delimiter();
    test_broken_escapes();
    test_random_strings(32, 88, 25);
    test_random_strings(88, 32, 25);
    test_random_strings(0, 0, 25);
    test_output_stall();

    end_open_string();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
